FILE: rtl/enc_spd_pkg.sv
// ----------------------------------------------------------------------------
// Encoder speed estimator package
// Shared constants, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package enc_spd_pkg;

  // Default angle resolution in bits.
  localparam int unsigned ANGLE_BITS_DEF = 12;

  // Fixed widths of the sample and result fields.
  localparam int unsigned RAW_ANGLE_W = 12;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned GEAR_W      = 16;
  localparam int unsigned RAD_W       = 16;
  localparam int unsigned RPM_W       = 32;
  localparam int unsigned FAULT_W     = 16;

  // Microseconds per minute and the width it needs.
  localparam int unsigned           US_PER_MIN_W = 26;
  localparam logic [US_PER_MIN_W-1:0] US_PER_MIN = 26'd60000000;

  // The speed numerator is at most 2^15 * 60e6, which fits in 41 bits
  // whatever the angle resolution.
  localparam int unsigned NUM_W = 41;
  // The divisor is only formed when the elapsed time fits the numerator.
  localparam int unsigned DIV_W = NUM_W + GEAR_W;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  // 2*pi in unsigned Q29.
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  localparam logic [GEAR_W-1:0] GEAR_RESET = 16'd256;

  localparam logic [RPM_W-1:0] RPM_MAX = 32'h7FFF_FFFF;
  localparam logic [RPM_W-1:0] RPM_MIN = 32'h8000_0000;

  // Operation codes of the op field.
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIV,
    ST_FILT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic prep;
    logic load;
    logic div_step;
    logic filt;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic speed;     // a speed is to be computed for this word
    logic quo_zero;  // elapsed time exceeds the numerator, quotient is zero
    logic div_last;  // final division step
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage : enc_spd_pkg

`default_nettype wire

FILE: rtl/encoder_speed_estimator_core.sv
// ----------------------------------------------------------------------------
// Encoder speed estimator core
// Turns magnetic angle samples into angle, radians and filtered rpm.
// ----------------------------------------------------------------------------
// Input words (op, raw_angle, magnet_present, bus_error, time_us) enter on a
// valid/ready channel; each gives exactly one result word on the output
// valid/ready channel. The gear ratio register is written through cfg_we_i
// and cfg_wdata_i; the user must do so only while the core is idle, as the
// core does not enforce it. A word whose speed needs a division passes
// through preparation, divider load, 41 steps of the one-bit-per-cycle
// restoring divider, filter and hand-over before its result is offered. A
// word whose elapsed time exceeds the speed numerator skips the divider;
// words without a speed also skip the filter. The core takes a new word
// only after hand-over of the last, and is ready the cycle after hand-over.
// The core accepts a new word as soon as the previous result has moved to the
// output register, even while that result waits for out_ready_i. If the
// receiver stalls, a finished result waits in the controller until the
// output register is free.
// Reset clears the sample history, the filter, the fault counter and any
// pending result, and sets the gear ratio to 1.0 (256 in Q8).
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_estimator_core #(
  parameter int unsigned ANGLE_BITS = enc_spd_pkg::ANGLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [enc_spd_pkg::GEAR_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic [enc_spd_pkg::RAW_ANGLE_W-1:0]  raw_angle_i,
  input  logic                                 magnet_present_i,
  input  logic                                 bus_error_i,
  input  logic [enc_spd_pkg::TIME_W-1:0]       time_us_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 ok_o,
  output logic                                 magnet_seen_o,
  output logic [enc_spd_pkg::RAW_ANGLE_W-1:0]  angle_out_o,
  output logic [enc_spd_pkg::RAD_W-1:0]        angle_rad_q13_o,
  output logic signed [enc_spd_pkg::RPM_W-1:0] rpm_q8_o,
  output logic                                 rpm_fresh_o,
  output logic [enc_spd_pkg::FAULT_W-1:0]      fault_count_o,
  output logic [enc_spd_pkg::TIME_W-1:0]       stamp_out_o
);
  import enc_spd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  enc_spd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  enc_spd_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .raw_angle_i      (raw_angle_i),
    .magnet_present_i (magnet_present_i),
    .bus_error_i      (bus_error_i),
    .time_us_i        (time_us_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ok_o             (ok_o),
    .magnet_seen_o    (magnet_seen_o),
    .angle_out_o      (angle_out_o),
    .angle_rad_q13_o  (angle_rad_q13_o),
    .rpm_q8_o         (rpm_q8_o),
    .rpm_fresh_o      (rpm_fresh_o),
    .fault_count_o    (fault_count_o),
    .stamp_out_o      (stamp_out_o)
  );

endmodule : encoder_speed_estimator_core

`default_nettype wire

FILE: rtl/enc_spd_ctrl.sv
// ----------------------------------------------------------------------------
// Encoder speed estimator controller
// Sequences one input word through preparation, the iterative division and
// the smoothing filter where needed, and the hand-over to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module enc_spd_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  enc_spd_pkg::dp_status_t status_i,
  output enc_spd_pkg::ctrl_cmd_t  cmd_o
);
  import enc_spd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        if (!status_i.speed) begin
          state_d = ST_EMIT;
        end else if (status_i.quo_zero) begin
          state_d = ST_FILT;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FILT;
        end
      end
      ST_FILT: begin
        cmd_o.filt = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule : enc_spd_ctrl

`default_nettype wire

FILE: rtl/enc_spd_dp.sv
// ----------------------------------------------------------------------------
// Encoder speed estimator datapath
// Holds the sensor state, the gear ratio register, the restoring divider,
// the exponential filter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module enc_spd_dp #(
  parameter int unsigned ANGLE_BITS = enc_spd_pkg::ANGLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [enc_spd_pkg::GEAR_W-1:0]       cfg_wdata_i,
  input  logic                                 op_i,
  input  logic [enc_spd_pkg::RAW_ANGLE_W-1:0]  raw_angle_i,
  input  logic                                 magnet_present_i,
  input  logic                                 bus_error_i,
  input  logic [enc_spd_pkg::TIME_W-1:0]       time_us_i,
  input  enc_spd_pkg::ctrl_cmd_t               cmd_i,
  output enc_spd_pkg::dp_status_t              status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 ok_o,
  output logic                                 magnet_seen_o,
  output logic [enc_spd_pkg::RAW_ANGLE_W-1:0]  angle_out_o,
  output logic [enc_spd_pkg::RAD_W-1:0]        angle_rad_q13_o,
  output logic signed [enc_spd_pkg::RPM_W-1:0] rpm_q8_o,
  output logic                                 rpm_fresh_o,
  output logic [enc_spd_pkg::FAULT_W-1:0]      fault_count_o,
  output logic [enc_spd_pkg::TIME_W-1:0]       stamp_out_o
);
  import enc_spd_pkg::*;

  localparam int unsigned D_W      = ANGLE_BITS + 2;
  localparam int unsigned MULNUM_W = ANGLE_BITS + US_PER_MIN_W;
  localparam int unsigned NUM_SH   = 16 - ANGLE_BITS;
  localparam int unsigned RADP_W   = ANGLE_BITS + 32;
  localparam logic signed [D_W-1:0] FULL = D_W'(1) <<< ANGLE_BITS;
  localparam logic signed [D_W-1:0] HALF = D_W'(1) <<< (ANGLE_BITS - 1);

  // Architectural state.
  logic [GEAR_W-1:0]     gear_q;
  logic [ANGLE_BITS-1:0] last_angle_q;
  logic [TIME_W-1:0]     last_time_q;
  logic [RPM_W-1:0]      smoothed_q;
  logic                  primed_q;
  logic [FAULT_W-1:0]    tally_q;
  logic                  out_valid_q;

  // Captured word and working registers.
  logic                  op_q;
  logic [ANGLE_BITS-1:0] angle_q;
  logic                  magnet_q;
  logic                  berr_q;
  logic [TIME_W-1:0]     now_q;
  logic                  speed_q;
  logic                  neg_q;
  logic [NUM_W-1:0]      num_q;
  logic [TIME_W-1:0]     dt_q;
  logic [RAD_W-1:0]      rad_q;
  logic [DIV_W-1:0]      divisor_q;
  logic [DIV_W-1:0]      rem_q;
  logic [NUM_W-1:0]      quo_q;
  logic [CNT_W-1:0]      cnt_q;

  // Output register.
  logic                  ok_q;
  logic                  magnet_seen_q;
  logic [RAW_ANGLE_W-1:0] angle_out_q;
  logic [RAD_W-1:0]      rad_out_q;
  logic [RPM_W-1:0]      rpm_q;
  logic                  fresh_q;
  logic [FAULT_W-1:0]    fault_q;
  logic [TIME_W-1:0]     stamp_q;

  // Angle difference, wrapped to plus or minus half a turn.
  logic signed [D_W-1:0]  diff_w;
  logic signed [D_W-1:0]  delta_w;
  logic [ANGLE_BITS-1:0]  mag_w;
  logic [MULNUM_W-1:0]    num_raw_w;
  logic [NUM_W-1:0]       num_w;
  logic [RADP_W-1:0]      rad_full_w;

  always_comb begin
    diff_w = $signed({2'b00, angle_q}) - $signed({2'b00, last_angle_q});
    if (diff_w > HALF) begin
      delta_w = diff_w - FULL;
    end else if (diff_w < -HALF) begin
      delta_w = diff_w + FULL;
    end else begin
      delta_w = diff_w;
    end
    mag_w      = delta_w[D_W-1] ? ANGLE_BITS'(-delta_w) : ANGLE_BITS'(delta_w);
    num_raw_w  = MULNUM_W'(mag_w) * MULNUM_W'(US_PER_MIN);
    num_w      = NUM_W'(num_raw_w) << NUM_SH;
    rad_full_w = RADP_W'(angle_q) * RADP_W'(TWO_PI_Q29)
               + (RADP_W'(1) << (ANGLE_BITS + 15));
  end

  // Divider support.
  logic [GEAR_W-1:0] gear_eff_w;
  logic [DIV_W:0]    trial_w;
  logic              fits_w;

  assign gear_eff_w = (gear_q == '0) ? GEAR_W'(1) : gear_q;
  assign trial_w    = {rem_q, quo_q[NUM_W-1]};
  assign fits_w     = trial_w >= {1'b0, divisor_q};

  // Saturation of the instantaneous speed and the smoothing filter.
  logic [RPM_W-1:0]         inst_w;
  logic signed [RPM_W:0]    fdiff_w;
  logic signed [RPM_W:0]    fstep_w;
  logic signed [RPM_W+1:0]  fsum_w;
  logic [RPM_W-1:0]         fnext_w;

  always_comb begin
    if (neg_q) begin
      inst_w = (quo_q >= NUM_W'(RPM_MIN)) ? RPM_MIN : -RPM_W'(quo_q);
    end else begin
      inst_w = (quo_q > NUM_W'(RPM_MAX)) ? RPM_MAX : RPM_W'(quo_q);
    end
    fdiff_w = $signed({inst_w[RPM_W-1], inst_w})
            - $signed({smoothed_q[RPM_W-1], smoothed_q});
    // Arithmetic shift gives the floor of a quarter.
    fstep_w = fdiff_w >>> 2;
    fsum_w  = $signed({{2{smoothed_q[RPM_W-1]}}, smoothed_q})
            + $signed({fstep_w[RPM_W], fstep_w});
    if (fsum_w[RPM_W+1:RPM_W-1] == 3'b000 || fsum_w[RPM_W+1:RPM_W-1] == 3'b111) begin
      fnext_w = fsum_w[RPM_W-1:0];
    end else if (fsum_w[RPM_W+1]) begin
      fnext_w = RPM_MIN;
    end else begin
      fnext_w = RPM_MAX;
    end
  end

  logic [FAULT_W-1:0] tally_next_w;
  assign tally_next_w = (tally_q == '1) ? tally_q : tally_q + FAULT_W'(1);

  // Status to the controller.
  assign status_o.speed    = speed_q;
  assign status_o.quo_zero = dt_q > TIME_W'(num_q);
  assign status_o.div_last = cnt_q == CNT_W'(NUM_W - 1);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q       <= GEAR_RESET;
      last_angle_q <= '0;
      last_time_q  <= '0;
      smoothed_q   <= '0;
      primed_q     <= 1'b0;
      tally_q      <= '0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        gear_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.filt) begin
        smoothed_q <= fnext_w;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        if (berr_q) begin
          tally_q <= tally_next_w;
        end else if (op_q == OP_START) begin
          if (magnet_q) begin
            last_angle_q <= angle_q;
            last_time_q  <= now_q;
            smoothed_q   <= '0;
            primed_q     <= 1'b1;
          end
        end else begin
          last_angle_q <= angle_q;
          last_time_q  <= now_q;
          primed_q     <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= op_i;
      angle_q  <= ANGLE_BITS'(raw_angle_i);
      magnet_q <= magnet_present_i;
      berr_q   <= bus_error_i;
      now_q    <= time_us_i;
    end
    if (cmd_i.prep) begin
      speed_q <= !berr_q && (op_q == OP_SAMPLE) && primed_q && (now_q > last_time_q);
      neg_q   <= delta_w[D_W-1];
      num_q   <= num_w;
      dt_q    <= now_q - last_time_q;
      rad_q   <= rad_full_w[RADP_W-1 -: RAD_W];
    end
    if (cmd_i.load) begin
      divisor_q <= DIV_W'(dt_q[NUM_W-1:0]) * DIV_W'(gear_eff_w);
      rem_q     <= '0;
      quo_q     <= status_o.quo_zero ? '0 : num_q;
    end else if (cmd_i.div_step) begin
      // The dividend shifts out of the top while quotient bits enter below.
      rem_q <= fits_w ? DIV_W'(trial_w - {1'b0, divisor_q}) : trial_w[DIV_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits_w};
    end
    if (cmd_i.emit) begin
      ok_q          <= !berr_q && magnet_q;
      magnet_seen_q <= !berr_q && magnet_q;
      angle_out_q   <= berr_q ? '0 : RAW_ANGLE_W'(angle_q);
      rad_out_q     <= berr_q ? '0 : rad_q;
      rpm_q         <= speed_q ? smoothed_q : '0;
      fresh_q       <= speed_q;
      fault_q       <= berr_q ? tally_next_w : tally_q;
      stamp_q       <= berr_q ? '0 : now_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign magnet_seen_o   = magnet_seen_q;
  assign angle_out_o     = angle_out_q;
  assign angle_rad_q13_o = rad_out_q;
  assign rpm_q8_o        = $signed(rpm_q);
  assign rpm_fresh_o     = fresh_q;
  assign fault_count_o   = fault_q;
  assign stamp_out_o     = stamp_q;

endmodule : enc_spd_dp

`default_nettype wire

FILE: dv/encoder_speed_estimator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed estimator checker
// Watches the configuration port and both word channels of the core. Every
// accepted input word is run through a local model of the angle, radians,
// speed and filter arithmetic. Every accepted result word is compared field
// by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module encoder_speed_estimator_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [enc_spd_pkg::GEAR_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic                                 op_i,
  input  logic [enc_spd_pkg::RAW_ANGLE_W-1:0]  raw_angle_i,
  input  logic                                 magnet_present_i,
  input  logic                                 bus_error_i,
  input  logic [enc_spd_pkg::TIME_W-1:0]       time_us_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic                                 ok_i,
  input  logic                                 magnet_seen_i,
  input  logic [enc_spd_pkg::RAW_ANGLE_W-1:0]  angle_out_i,
  input  logic [enc_spd_pkg::RAD_W-1:0]        angle_rad_q13_i,
  input  logic signed [enc_spd_pkg::RPM_W-1:0] rpm_q8_i,
  input  logic                                 rpm_fresh_i,
  input  logic [enc_spd_pkg::FAULT_W-1:0]      fault_count_i,
  input  logic [enc_spd_pkg::TIME_W-1:0]       stamp_out_i,
  output int                                   mismatches_o,
  output int                                   awaiting_o,
  output int                                   checked_o
);

  import enc_spd_pkg::*;

  localparam int ANGLE_BITS = ANGLE_BITS_DEF;
  localparam int FULL_TURN  = 1 << ANGLE_BITS;
  localparam int HALF_TURN  = 1 << (ANGLE_BITS - 1);

  typedef struct packed {
    logic                     ok;
    logic                     magnet_seen;
    logic [RAW_ANGLE_W-1:0]   angle;
    logic [RAD_W-1:0]         rad;
    logic signed [RPM_W-1:0]  rpm;
    logic                     fresh;
    logic [FAULT_W-1:0]       faults;
    logic [TIME_W-1:0]        stamp;
  } speed_report_t;

  // Local copy of the configuration and the sample history.
  logic [GEAR_W-1:0]       gear_q8;
  logic [RAW_ANGLE_W-1:0]  last_angle;
  logic [TIME_W-1:0]       last_stamp;
  logic signed [RPM_W-1:0] smoothed;
  logic                    primed;
  logic [FAULT_W-1:0]      fault_tally;

  speed_report_t awaited_reports[$];
  speed_report_t seen;
  speed_report_t want;

  initial begin
    mismatches_o = 0;
    awaiting_o   = 0;
    checked_o    = 0;
  end

  function automatic logic [RAD_W-1:0] angle_to_q13(logic [RAW_ANGLE_W-1:0] a);
    logic [63:0] prod;
    prod = 64'(a) * 64'(TWO_PI_Q29) + (64'd1 << (ANGLE_BITS + 15));
    return prod[ANGLE_BITS+16 +: RAD_W];
  endfunction

  function automatic logic signed [RPM_W-1:0] raw_speed_q8(int delta,
                                                           logic [TIME_W-1:0] dt);
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] divisor;
    logic [63:0] quo;
    mag     = (delta < 0) ? 64'(-delta) : 64'(delta);
    num     = (mag * 64'd60000000) << (16 - ANGLE_BITS);
    // A zero gear ratio divides as if it were one.
    divisor = 64'(dt) * ((gear_q8 == '0) ? 64'd1 : 64'(gear_q8));
    quo     = (64'(dt) > num) ? 64'd0 : num / divisor;
    if (delta < 0) begin
      return (quo >= 64'h8000_0000) ? $signed(RPM_MIN) : -$signed(quo[31:0]);
    end
    return (quo > 64'h7FFF_FFFF) ? $signed(RPM_MAX) : $signed(quo[31:0]);
  endfunction

  // Weight 1/4 filter; the shift floors negative steps.
  function automatic logic signed [RPM_W-1:0] filter_speed(logic signed [RPM_W-1:0] prev,
                                                           logic signed [RPM_W-1:0] inst);
    longint diff;
    longint next;
    diff = longint'(inst) - longint'(prev);
    next = longint'(prev) + (diff >>> 2);
    if (next > longint'(32'sh7FFF_FFFF)) next = longint'(32'sh7FFF_FFFF);
    if (next < longint'(32'sh8000_0000)) next = longint'(32'sh8000_0000);
    return 32'(next);
  endfunction

  function automatic speed_report_t predict_report(logic op, logic [RAW_ANGLE_W-1:0] angle,
                                                   logic magnet, logic berr,
                                                   logic [TIME_W-1:0] stamp);
    speed_report_t r;
    int delta;
    r = '0;
    if (berr) begin
      if (fault_tally != '1) fault_tally = fault_tally + 1'b1;
      r.faults = fault_tally;
      return r;
    end
    r.magnet_seen = magnet;
    r.angle       = angle;
    r.rad         = angle_to_q13(angle);
    r.faults      = fault_tally;
    r.stamp       = stamp;
    if (op == OP_START) begin
      // Priming only takes hold when the magnet is there.
      if (magnet) begin
        last_angle = angle;
        last_stamp = stamp;
        smoothed   = '0;
        primed     = 1'b1;
        r.ok       = 1'b1;
      end
    end else begin
      r.ok = magnet;
      if (primed && stamp > last_stamp) begin
        delta = int'(angle) - int'(last_angle);
        if (delta > HALF_TURN) delta -= FULL_TURN;
        if (delta < -HALF_TURN) delta += FULL_TURN;
        smoothed = filter_speed(smoothed, raw_speed_q8(delta, stamp - last_stamp));
        r.rpm    = smoothed;
        r.fresh  = 1'b1;
      end
      last_angle = angle;
      last_stamp = stamp;
      primed     = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q8     = GEAR_RESET;
      last_angle  = '0;
      last_stamp  = '0;
      smoothed    = '0;
      primed      = 1'b0;
      fault_tally = '0;
      awaited_reports.delete();
      awaiting_o  = 0;
    end else begin
      if (cfg_we_i) gear_q8 = cfg_wdata_i;

      // Results leave before the new word is predicted, as they belong to older words.
      if (out_valid_i && out_ready_i) begin
        seen.ok          = ok_i;
        seen.magnet_seen = magnet_seen_i;
        seen.angle       = angle_out_i;
        seen.rad         = angle_rad_q13_i;
        seen.rpm         = rpm_q8_i;
        seen.fresh       = rpm_fresh_i;
        seen.faults      = fault_count_i;
        seen.stamp       = stamp_out_i;
        if (awaited_reports.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("result word %0d arrived with no input word outstanding", checked_o);
        end else begin
          want = awaited_reports.pop_front();
          if (seen.ok !== want.ok || seen.magnet_seen !== want.magnet_seen ||
              seen.angle !== want.angle || seen.rad !== want.rad ||
              seen.rpm !== want.rpm || seen.fresh !== want.fresh ||
              seen.faults !== want.faults || seen.stamp !== want.stamp) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("result word %0d expected ok=%0b mag=%0b ang=%0d rad=%0d rpm=%0d fresh=%0b flt=%0d stamp=%0h",
                       checked_o, want.ok, want.magnet_seen, want.angle, want.rad,
                       want.rpm, want.fresh, want.faults, want.stamp);
              $display("result word %0d actual   ok=%0b mag=%0b ang=%0d rad=%0d rpm=%0d fresh=%0b flt=%0d stamp=%0h",
                       checked_o, seen.ok, seen.magnet_seen, seen.angle, seen.rad,
                       seen.rpm, seen.fresh, seen.faults, seen.stamp);
            end
          end
        end
        checked_o++;
      end

      if (in_valid_i && in_ready_i)
        awaited_reports.push_back(predict_report(op_i, raw_angle_i, magnet_present_i,
                                                 bus_error_i, time_us_i));
      awaiting_o = awaited_reports.size();
    end
  end

endmodule

FILE: dv/encoder_speed_estimator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed estimator core testbench
// Drives angle sample words into the core under a series of gear ratios,
// with random idling on both channels and one long output stall. A checker
// beside the core predicts and compares every result word.
// ----------------------------------------------------------------------------

module encoder_speed_estimator_core_test;

  import enc_spd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int          PHASE_WORDS  = 122;
  localparam int          SETTLE_TICKS = 60;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we      = 1'b0;
  logic [GEAR_W-1:0]       cfg_wdata   = '0;
  logic                    in_valid    = 1'b0;
  logic                    in_ready;
  logic                    op          = OP_SAMPLE;
  logic [RAW_ANGLE_W-1:0]  raw_angle   = '0;
  logic                    magnet      = 1'b0;
  logic                    bus_error   = 1'b0;
  logic [TIME_W-1:0]       time_us     = '0;
  logic                    out_valid;
  logic                    out_ready   = 1'b0;
  logic                    ok;
  logic                    magnet_seen;
  logic [RAW_ANGLE_W-1:0]  angle_out;
  logic [RAD_W-1:0]        angle_rad_q13;
  logic signed [RPM_W-1:0] rpm_q8;
  logic                    rpm_fresh;
  logic [FAULT_W-1:0]      fault_count;
  logic [TIME_W-1:0]       stamp_out;

  int          mismatches;
  int          awaiting;
  int          checked;
  int          words_sent  = 0;
  int          gear_writes = 0;
  int unsigned cycles      = 0;
  bit          calm        = 1'b0;
  bit          long_hold   = 1'b0;

  always #4 clk_i = ~clk_i;

  encoder_speed_estimator_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .op_i             (op),
    .raw_angle_i      (raw_angle),
    .magnet_present_i (magnet),
    .bus_error_i      (bus_error),
    .time_us_i        (time_us),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .ok_o             (ok),
    .magnet_seen_o    (magnet_seen),
    .angle_out_o      (angle_out),
    .angle_rad_q13_o  (angle_rad_q13),
    .rpm_q8_o         (rpm_q8),
    .rpm_fresh_o      (rpm_fresh),
    .fault_count_o    (fault_count),
    .stamp_out_o      (stamp_out)
  );

  encoder_speed_estimator_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .op_i             (op),
    .raw_angle_i      (raw_angle),
    .magnet_present_i (magnet),
    .bus_error_i      (bus_error),
    .time_us_i        (time_us),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .ok_i             (ok),
    .magnet_seen_i    (magnet_seen),
    .angle_out_i      (angle_out),
    .angle_rad_q13_i  (angle_rad_q13),
    .rpm_q8_i         (rpm_q8),
    .rpm_fresh_i      (rpm_fresh),
    .fault_count_i    (fault_count),
    .stamp_out_i      (stamp_out),
    .mismatches_o     (mismatches),
    .awaiting_o       (awaiting),
    .checked_o        (checked)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] rand_stamp();
    return {16'($urandom), $urandom};
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_word(input logic op_v, input logic [RAW_ANGLE_W-1:0] angle_v,
                            input logic magnet_v, input logic berr_v,
                            input logic [TIME_W-1:0] stamp_v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid  <= 1'b0;
      op        <= 1'($urandom);
      raw_angle <= 12'($urandom);
      magnet    <= 1'($urandom);
      bus_error <= 1'($urandom);
      time_us   <= rand_stamp();
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    op        <= op_v;
    raw_angle <= angle_v;
    magnet    <= magnet_v;
    bus_error <= berr_v;
    time_us   <= stamp_v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Waits until every result word is back and the core has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (awaiting != 0);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic write_gear(input logic [GEAR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    gear_writes++;
  endtask

  // A primed run of samples with sensible time steps, salted with faults,
  // restarts, stale timestamps and plain noise.
  task automatic run_track(input int len);
    logic [RAW_ANGLE_W-1:0] angle;
    logic [TIME_W-1:0]      stamp;
    int                     step;
    int                     pick;
    angle = 12'($urandom);
    stamp = ($urandom_range(0, 7) == 0) ? ('1 - 48'($urandom_range(0, 100000))) : rand_stamp();
    offer_word(OP_START, angle, $urandom_range(0, 9) != 0, 1'b0, stamp);
    for (int k = 1; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        offer_word(1'($urandom), 12'($urandom), 1'($urandom), 1'b1, rand_stamp());
      end else if (pick < 10) begin
        angle = 12'($urandom);
        offer_word(OP_START, angle, 1'($urandom), 1'b0, stamp);
      end else if (pick < 14) begin
        angle = angle + 12'($urandom_range(0, 200));
        stamp = stamp - 48'($urandom_range(0, 3));
        offer_word(OP_SAMPLE, angle, 1'b1, 1'b0, stamp);
      end else if (pick < 17) begin
        offer_word(1'($urandom), 12'($urandom), 1'($urandom), 1'b0, rand_stamp());
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: step = int'($urandom_range(0, 80)) - 40;
          5, 6, 7:       step = int'($urandom_range(0, 1200)) - 600;
          8:             step = ($urandom_range(0, 1) ? 2048 : -2048) +
                                int'($urandom_range(0, 2)) - 1;
          default:       step = int'($urandom_range(0, 4095));
        endcase
        angle = angle + 12'(step);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: stamp = stamp + 48'($urandom_range(1, 5000));
          6, 7:             stamp = stamp + 48'($urandom_range(1, 1 << 20));
          8:                stamp = stamp + 48'($urandom_range(1, 50));
          default:          stamp = stamp + rand_stamp();
        endcase
        offer_word(OP_SAMPLE, angle, $urandom_range(0, 9) != 0, 1'b0, stamp);
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, none once calm.
  initial begin : receiver
    @(negedge clk_i);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [GEAR_W-1:0] gear_plan [10];
    int                target;
    gear_plan = '{16'd1, 16'd65535, 16'd0, 16'd256, 16'd3, 16'($urandom), 16'd40000,
                  16'($urandom_range(2, 64)), 16'($urandom), 16'd128};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words under the reset gear ratio.
    offer_word(OP_SAMPLE, 12'd4095, 1'b1, 1'b1, '1);               // fault word
    offer_word(OP_SAMPLE, 12'd0, 1'b1, 1'b0, 48'd10);              // not yet primed
    offer_word(OP_START, 12'd1234, 1'b0, 1'b0, 48'd20);            // start, no magnet
    offer_word(OP_START, 12'd4095, 1'b1, 1'b0, 48'd1000);          // start primes
    offer_word(OP_SAMPLE, 12'd0, 1'b1, 1'b0, 48'd1001);            // wraps forward by one
    offer_word(OP_SAMPLE, 12'd2048, 1'b1, 1'b0, 48'd1002);         // half turn, saturates
    offer_word(OP_SAMPLE, 12'd0, 1'b1, 1'b0, 48'd1003);            // minus half turn
    offer_word(OP_SAMPLE, 12'd0, 1'b1, 1'b0, 48'd1003);            // same timestamp
    offer_word(OP_SAMPLE, 12'd100, 1'b1, 1'b0, 48'd500);           // time goes back
    offer_word(OP_SAMPLE, 12'd200, 1'b0, 1'b0, 48'd600);           // no magnet, speed kept
    offer_word(OP_SAMPLE, 12'd300, 1'b1, 1'b0, '1);                // huge gap, zero speed
    offer_word(OP_START, 12'd0, 1'b1, 1'b0, 48'd0);
    offer_word(OP_SAMPLE, 12'd2049, 1'b1, 1'b0, 48'd7);            // wraps backwards
    offer_word(OP_SAMPLE, 12'd0, 1'b1, 1'b0, 48'd8);               // wraps forwards
    offer_word(OP_START, 12'd55, 1'b1, 1'b1, 48'd9);               // fault on a start
    offer_word(OP_SAMPLE, 12'd4095, 1'b1, 1'b0, 48'h8000_0000_0000);
    offer_word(OP_START, 12'd2048, 1'b1, 1'b0, 48'hFFFF_FFFF_FFFE);
    offer_word(OP_SAMPLE, 12'd2047, 1'b1, 1'b0, 48'hFFFF_FFFF_FFFF);
    offer_word(OP_SAMPLE, 12'd2047, 1'b1, 1'b0, 48'd3);

    for (int p = 0; p < 10; p++) begin
      settle();
      write_gear(gear_plan[p]);
      if (p == 1) long_hold = 1'b1;
      // From here on neither side idles.
      if (p == 8) calm = 1'b1;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) run_track($urandom_range(4, 40));
    end

    in_valid <= 1'b0;
    do @(negedge clk_i); while (awaiting != 0);
    repeat (100) @(negedge clk_i);

    $display("Run covered %0d input words over %0d gear ratio writes, with one long stall,",
             words_sent, gear_writes);
    $display("with %0d result words checked and %0d mismatches.", checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
